FILE: hw/rtl/mxt_pkg.sv
// Shared types, sizes and trie-entry helpers for the max-XOR-pair trie block.
// No dependencies; imported by mxt_walker, max_xor_pair_binary_trie and the testbench.
`default_nettype none

package mxt_pkg;

  localparam int unsigned WIDTH = 32;     // bits per number, 1..32
  localparam int unsigned NODES = 65536;  // node pool size, root included

  localparam int unsigned IDX_W = $clog2(NODES);
  localparam int unsigned ENT_W = 2 * IDX_W;
  localparam int unsigned NF_W  = $clog2(NODES + 1);
  localparam int unsigned LVL_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [ENT_W-1:0] ent_t;
  typedef logic [NF_W-1:0]  nfree_t;
  typedef logic [LVL_W-1:0] lvl_t;
  typedef logic [WIDTH-1:0] val_t;

  // status of one finished query/insert pass
  typedef struct packed {
    logic done;
    logic ovf;
    val_t acc;
  } walk_res_t;

  // entry layout: child for bit 0 in the low half, child for bit 1 in the high half
  function automatic idx_t child_of(ent_t e, logic b);
    return b ? e[ENT_W-1:IDX_W] : e[IDX_W-1:0];
  endfunction

  function automatic ent_t set_child(ent_t e, logic b, idx_t idx);
    ent_t r;
    r = e;
    if (b) begin
      r[ENT_W-1:IDX_W] = idx;
    end else begin
      r[IDX_W-1:0] = idx;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/max_xor_pair_binary_trie.sv
// Top level of the max-XOR-pair trie: input/output handshakes, per-set running state.
// Depends on mxt_pkg and mxt_walker.
//
// Usage: numbers of a set arrive as beats on the input channel (value_i, last_i).
// Each number is looked up in the trie for its best XOR partner, then stored.
// The beat with last_i high produces one result beat (max_xor_o, overflow_o);
// other beats produce none. After the last beat the trie is emptied.
// Per beat: a trie walk (query and insert paths in parallel on two read ports of
// the node store, one level per cycle), a pool check and, when new nodes are
// needed, a write of the parent link and then of each new node, followed by the
// hand-off to the top level. On the last beat of a set the result is then loaded
// into the output register.
// in_ready_o is high only between beats; the block works on one number at a time.
// A result waits in an output register; if it is not taken when the next set's
// last result is due, the block holds until the output frees up.
// overflow_o reports that the node pool ran out during the set; numbers that
// did not fit still took part in the query.
// Reset empties the trie at once (root held in flops), no clearing pass.
`default_nettype none

module max_xor_pair_binary_trie
  import mxt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] value_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      max_xor_o,
  output logic             overflow_o
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_BUSY = 2'd1;
  localparam logic [1:0] T_HOLD = 2'd2;

  logic [1:0]  t_state_q, t_state_d;
  logic        last_q, last_d;
  val_t        run_max_q, run_max_d;
  logic        ovf_seen_q, ovf_seen_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_max_q, out_max_d;
  logic        out_ovf_q, out_ovf_d;

  logic        accept;
  logic        slot_free;
  logic        clear_set;
  walk_res_t   w_res;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  mxt_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .value_i (value_i[WIDTH-1:0]),
    .clear_i (clear_set),
    .res_o   (w_res)
  );

  always_comb begin
    t_state_d   = t_state_q;
    last_d      = last_q;
    run_max_d   = run_max_q;
    ovf_seen_d  = ovf_seen_q;
    out_valid_d = out_valid_q;
    out_max_d   = out_max_q;
    out_ovf_d   = out_ovf_q;
    clear_set   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (t_state_q)
      T_IDLE: begin
        if (accept) begin
          last_d    = last_i;
          t_state_d = T_BUSY;
        end
      end
      T_BUSY: begin
        if (w_res.done) begin
          if (w_res.acc > run_max_q) begin
            run_max_d = w_res.acc;
          end
          ovf_seen_d = ovf_seen_q | w_res.ovf;
          t_state_d  = last_q ? T_HOLD : T_IDLE;
        end
      end
      T_HOLD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_max_d   = 32'(run_max_q);
          out_ovf_d   = ovf_seen_q;
          run_max_d   = '0;
          ovf_seen_d  = 1'b0;
          clear_set   = 1'b1;
          t_state_d   = T_IDLE;
        end
      end
      default: begin
        t_state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_state_q   <= T_IDLE;
      run_max_q   <= '0;
      ovf_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      t_state_q   <= t_state_d;
      run_max_q   <= run_max_d;
      ovf_seen_q  <= ovf_seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q    <= last_d;
    out_max_q <= out_max_d;
    out_ovf_q <= out_ovf_d;
  end

  assign in_ready_o  = (t_state_q == T_IDLE);
  assign out_valid_o = out_valid_q;
  assign max_xor_o   = out_max_q;
  assign overflow_o  = out_ovf_q;

  // a beat occupies the block until its walk finishes
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input accepted back to back");

  a_done_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_res.done |-> (t_state_q == T_BUSY))
    else $error("walker finished with no beat in flight");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (t_state_q == T_HOLD) && slot_free |=> out_valid_o && in_ready_o)
    else $error("set result not presented");

  a_no_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_set |-> !w_res.done && (t_state_q == T_HOLD))
    else $error("trie cleared outside end of set");

endmodule

`default_nettype wire

FILE: hw/rtl/mxt_walker.sv
// Trie walker: node store, query and insert walks one level per cycle, node writes.
// Depends on mxt_pkg.
`default_nettype none

module mxt_walker
  import mxt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire val_t      value_i,
  input  wire logic      clear_i,
  output walk_res_t      res_o
);

  localparam logic [2:0] W_IDLE = 3'd0;
  localparam logic [2:0] W_WALK = 3'd1;
  localparam logic [2:0] W_CHK  = 3'd2;
  localparam logic [2:0] W_PAR  = 3'd3;
  localparam logic [2:0] W_NEW  = 3'd4;

  // node 0 (root) lives in flops; the array holds nodes 1 and up
  ent_t node_mem [NODES];

  logic [2:0] state_q, state_d;
  lvl_t       lvl_q, lvl_d;
  val_t       val_q, val_d;
  idx_t       qnode_q, qnode_d;
  idx_t       inode_q, inode_d;
  logic       qdone_q, qdone_d;
  logic       idone_q, idone_d;
  logic       miss_q, miss_d;
  val_t       acc_q, acc_d;
  lvl_t       dlvl_q, dlvl_d;
  idx_t       pnode_q, pnode_d;
  ent_t       pent_q, pent_d;
  ent_t       root_q, root_d;
  nfree_t     nfree_q, nfree_d;
  logic       done_q, done_d;
  logic       ovf_q, ovf_d;
  ent_t       ra_data_q, rb_data_q;

  ent_t       qent, ient;
  logic       b;
  idx_t       qopp, qsame, inxt;
  lvl_t       lvl_m1;
  idx_t       nf_idx;
  logic [NF_W:0] need_sum;
  logic       mem_we;
  idx_t       rb_addr;
  ent_t       mem_wdata;

  always_comb begin
    state_d  = state_q;
    lvl_d    = lvl_q;
    val_d    = val_q;
    qnode_d  = qnode_q;
    inode_d  = inode_q;
    qdone_d  = qdone_q;
    idone_d  = idone_q;
    miss_d   = miss_q;
    acc_d    = acc_q;
    dlvl_d   = dlvl_q;
    pnode_d  = pnode_q;
    pent_d   = pent_q;
    root_d   = root_q;
    nfree_d  = nfree_q;
    done_d   = 1'b0;
    ovf_d    = ovf_q;
    mem_we   = 1'b0;
    mem_wdata = '0;

    qent   = (qnode_q == idx_t'(0)) ? root_q : ra_data_q;
    ient   = (inode_q == idx_t'(0)) ? root_q : rb_data_q;
    b      = val_q[lvl_q];
    qopp   = child_of(qent, ~b);
    qsame  = child_of(qent, b);
    inxt   = child_of(ient, b);
    lvl_m1 = lvl_t'(lvl_q - 1'b1);
    nf_idx = nfree_q[IDX_W-1:0];
    need_sum = (NF_W+1)'(nfree_q) + (NF_W+1)'(dlvl_q) + (NF_W+1)'(1);
    rb_addr  = '0;

    unique case (state_q)
      W_IDLE: begin
        if (start_i) begin
          state_d = W_WALK;
          lvl_d   = lvl_t'(WIDTH - 1);
          val_d   = value_i;
          qnode_d = '0;
          inode_d = '0;
          qdone_d = 1'b0;
          idone_d = 1'b0;
          miss_d  = 1'b0;
          acc_d   = '0;
          ovf_d   = 1'b0;
        end
      end
      W_WALK: begin
        // query path: prefer the opposite bit, stop on a dead end
        if (!qdone_q) begin
          if (qopp != idx_t'(0)) begin
            acc_d   = acc_q | (val_t'(1) << lvl_q);
            qnode_d = qopp;
          end else if (qsame != idx_t'(0)) begin
            qnode_d = qsame;
          end else begin
            qdone_d = 1'b1;
          end
        end
        // insert path: find the first missing link
        if (!idone_q) begin
          if (inxt == idx_t'(0)) begin
            idone_d = 1'b1;
            miss_d  = 1'b1;
            dlvl_d  = lvl_q;
            pnode_d = inode_q;
            pent_d  = ient;
          end else begin
            inode_d = inxt;
          end
        end
        if (lvl_q == lvl_t'(0)) begin
          state_d = W_CHK;
        end else begin
          lvl_d = lvl_m1;
        end
      end
      W_CHK: begin
        if (!miss_q) begin
          state_d = W_IDLE;
          done_d  = 1'b1;
        end else if (need_sum > (NF_W+1)'(NODES)) begin
          state_d = W_IDLE;
          ovf_d   = 1'b1;
          done_d  = 1'b1;
        end else begin
          state_d = W_PAR;
        end
      end
      W_PAR: begin
        // hook the first new node under the existing parent
        mem_wdata = set_child(pent_q, val_q[dlvl_q], nf_idx);
        if (pnode_q == idx_t'(0)) begin
          root_d = mem_wdata;
        end else begin
          mem_we  = 1'b1;
          rb_addr = pnode_q;
        end
        lvl_d   = dlvl_q;
        state_d = W_NEW;
      end
      W_NEW: begin
        // new nodes are numbered in path order, each pointing at the next
        mem_we  = 1'b1;
        rb_addr = nf_idx;
        nfree_d = nfree_t'(nfree_q + 1'b1);
        if (lvl_q == lvl_t'(0)) begin
          mem_wdata = '0;
          state_d   = W_IDLE;
          done_d    = 1'b1;
        end else begin
          mem_wdata = set_child('0, val_q[lvl_m1], idx_t'(nf_idx + 1'b1));
          lvl_d     = lvl_m1;
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase

    if (!mem_we) begin
      rb_addr = inode_d;
    end

    if (clear_i) begin
      root_d  = '0;
      nfree_d = nfree_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem[rb_addr] <= mem_wdata;
    end
    ra_data_q <= node_mem[qnode_d];
    rb_data_q <= node_mem[rb_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      root_q  <= '0;
      nfree_q <= nfree_t'(1);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      root_q  <= root_d;
      nfree_q <= nfree_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q   <= lvl_d;
    val_q   <= val_d;
    qnode_q <= qnode_d;
    inode_q <= inode_d;
    qdone_q <= qdone_d;
    idone_q <= idone_d;
    miss_q  <= miss_d;
    acc_q   <= acc_d;
    dlvl_q  <= dlvl_d;
    pnode_q <= pnode_d;
    pent_q  <= pent_d;
    ovf_q   <= ovf_d;
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.acc  = acc_q;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for max_xor_pair_binary_trie: a directed table and random sets.
// Results are checked against a trie-based max-XOR predictor. Depends on mxt_pkg and the block RTL.

module testbench;
  import mxt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RANDOM_BEATS = 926;
  localparam int unsigned DRAIN_CYCLES = 80;       // final wait: the worst beat plus margin
  localparam int unsigned N_DIRECTED = 24;

  typedef struct packed {
    val_t max_xor;
    logic ovf;
  } set_result_t;

  typedef struct packed {
    val_t value;
    logic last;
    logic typed;    // expected result given in the row
    val_t max_xor;
    logic ovf;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] value_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] max_xor_o;
  logic        overflow_o;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned burst_left = 0;
  set_result_t pending_results[$];

  // predictor state: one trie per set
  int unsigned trie_child0 [NODES];
  int unsigned trie_child1 [NODES];
  int unsigned trie_next_free = 1;
  val_t        set_max = '0;
  bit          set_ovf = 1'b0;
  bit          set_empty = 1'b1;

  row_t directed_rows [N_DIRECTED] = '{
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},  // lone number after reset
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{32'h1234_5678, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000, 1'b0},  // duplicate adds no node
    '{32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0004, 1'b1, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0003, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0000_000A, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0019, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0008, 1'b1, 1'b0, 32'h0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h5555_5555, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0001, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h8000_0001, 1'b1, 1'b0, 32'h0, 1'b0}
  };

  max_xor_pair_binary_trie DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .max_xor_o  (max_xor_o),
    .overflow_o (overflow_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void trie_clear();
    trie_child0[0] = 0;
    trie_child1[0] = 0;
    trie_next_free = 1;
    set_max = '0;
    set_ovf = 1'b0;
    set_empty = 1'b1;
  endfunction

  // walk MSB first, taking the opposite-bit branch whenever it exists
  function automatic val_t best_partner_xor(val_t v);
    int unsigned node;
    int unsigned opp;
    int unsigned same;
    bit walking;
    val_t acc;
    node = 0;
    acc = '0;
    walking = 1'b1;
    for (int lvl = WIDTH - 1; lvl >= 0; lvl--) begin
      if (walking) begin
        opp = v[lvl] ? trie_child0[node] : trie_child1[node];
        same = v[lvl] ? trie_child1[node] : trie_child0[node];
        if (opp != 0) begin
          acc[lvl] = 1'b1;
          node = opp;
        end else if (same != 0) begin
          node = same;
        end else begin
          walking = 1'b0;
        end
      end
    end
    return acc;
  endfunction

  function automatic void trie_store(val_t v);
    int unsigned node;
    int unsigned nxt;
    int unsigned needed;
    node = 0;
    needed = 0;
    for (int lvl = WIDTH - 1; lvl >= 0; lvl--) begin
      if (needed == 0) begin
        nxt = v[lvl] ? trie_child1[node] : trie_child0[node];
        if (nxt == 0) begin
          needed = lvl + 1;
        end else begin
          node = nxt;
        end
      end
    end
    if (needed == 0) begin
      set_empty = 1'b0;
      return;
    end
    // all or nothing: a path that does not fit is not started
    if (longint'(trie_next_free) + needed > longint'(NODES)) begin
      set_ovf = 1'b1;
      return;
    end
    node = 0;
    for (int lvl = WIDTH - 1; lvl >= 0; lvl--) begin
      nxt = v[lvl] ? trie_child1[node] : trie_child0[node];
      if (nxt == 0) begin
        nxt = trie_next_free;
        trie_next_free++;
        trie_child0[nxt] = 0;
        trie_child1[nxt] = 0;
        if (v[lvl]) begin
          trie_child1[node] = nxt;
        end else begin
          trie_child0[node] = nxt;
        end
      end
      node = nxt;
    end
    set_empty = 1'b0;
  endfunction

  function automatic bit predict_set_result(val_t v, logic is_last, output set_result_t res);
    val_t x;
    if (!set_empty) begin
      x = best_partner_xor(v);
      if (x > set_max) begin
        set_max = x;
      end
    end
    trie_store(v);
    res.max_xor = set_max;
    res.ovf = set_ovf;
    if (is_last) begin
      trie_clear();
    end
    return is_last;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < 40) begin
      $display("MISMATCH %s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
    end
    error_count++;
  endtask

  // drive one beat, wait for acceptance, then record what it should produce
  task automatic send_number(val_t v, logic is_last, bit typed, set_result_t typed_res,
                             bit bursty);
    int unsigned gap;
    set_result_t res;
    gap = 0;
    if (bursty) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= v;
    last_i <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_set_result(v, is_last, res)) begin
      pending_results.push_back(typed ? typed_res : res);
    end
  endtask

  function automatic val_t pick_number(val_t base);
    val_t v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 15);
      1: v = base ^ (val_t'(1) << $urandom_range(0, WIDTH - 1));
      2: v = base ^ val_t'($urandom_range(0, 255));
      3: v = val_t'($urandom_range(0, 15)) << (WIDTH - 4);
      4: v = base;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check each taken beat, stall on a pattern that shifts mode now and then
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk_i) begin : result_check
    set_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", max_xor_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (max_xor_o !== want.max_xor) begin
          report_mismatch("max_xor", max_xor_o, want.max_xor);
        end
        if (overflow_o !== want.ovf) begin
          report_mismatch("overflow", 32'(overflow_o), 32'(want.ovf));
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(100, 800);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= (cycle_count[4:3] != 2'b00);
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned set_len;
    val_t base;
    set_result_t typed_res;
    trie_clear();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      typed_res.max_xor = directed_rows[i].max_xor;
      typed_res.ovf = directed_rows[i].ovf;
      send_number(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
                  typed_res, 1'b1);
    end

    typed_res = '0;
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      base = $urandom();
      for (int unsigned k = 0; k < set_len; k++) begin
        send_number(pick_number(base), k == set_len - 1, 1'b0, typed_res, 1'b1);
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
